@@ sv/adam_parameter_update_defines.svh @@
// ----------------------------------------------------------------------------
// Adam parameter update - assertion macros
// Concurrent check wrappers for the files that assert.
// ----------------------------------------------------------------------------
`ifndef ADAM_PARAMETER_UPDATE_DEFINES_SVH
`define ADAM_PARAMETER_UPDATE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define APU_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define APU_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/apu_pkg.sv @@
// ----------------------------------------------------------------------------
// Adam parameter update - package
// Shared constants, request codes and arithmetic unit command types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package apu_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int IDX_W           = 10;
    localparam int TYPE_W          = 2;
    localparam int CFG_W           = 32;
    localparam int CFG_IDX_W       = 2;
    localparam int XW              = 64;       // internal datapath width
    localparam int HW              = XW / 2;   // multiplier operand width
    localparam int FRAC_BITS       = 24;

    localparam logic [XW-1:0] ONE_Q32 = XW'(64'h1_0000_0000);

    localparam logic [CFG_W-1:0] LR_RST  = 32'd4294967;
    localparam logic [CFG_W-1:0] B1_RST  = 32'd3865470566;
    localparam logic [CFG_W-1:0] B2_RST  = 32'd4290672329;
    localparam logic [CFG_W-1:0] EPS_RST = 32'd43;

    localparam logic [CFG_IDX_W-1:0] CFG_LR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS   = 2'd3;

    typedef enum logic [TYPE_W-1:0] {
        REQ_LOAD   = 2'd0,
        REQ_GRAD   = 2'd1,
        REQ_ADV    = 2'd2,
        REQ_IGNORE = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_cmd_t;

    typedef struct packed {
        logic done;
        logic div_sat;
    } arith_stat_t;

endpackage

`default_nettype wire

@@ sv/apu_ram.sv @@
// ----------------------------------------------------------------------------
// Adam parameter update - generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module apu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ sv/apu_arith.sv @@
// ----------------------------------------------------------------------------
// Adam parameter update - shared arithmetic unit
// 64x64 multiply from four registered 32x32 partial products, restoring
// 128/64 divide of (a << 32) by b, and 64-bit integer root of (a << 40),
// both one bit a cycle through a single shared subtractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module apu_arith
    import apu_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire arith_cmd_t    cmd,
    input  wire logic [XW-1:0] opa,
    input  wire logic [XW-1:0] opb,
    output arith_stat_t        stat,
    output logic [2*XW-1:0]    prod,
    output logic [XW-1:0]      quo
);

    localparam int CW = $clog2(XW);
    localparam logic [CW-1:0] MUL_LAST = CW'(4);
    localparam logic [CW-1:0] ITER_LAST = CW'(XW - 1);

    arith_op_t        op_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             dsat_reg;
    logic [CW-1:0]    cnt_reg;
    logic [XW-1:0]    a_reg;
    logic [XW-1:0]    b_reg;
    logic [XW-1:0]    pp_reg;
    logic [1:0]       kp_reg;
    logic [2*XW-1:0]  acc_reg;
    logic [2*XW-1:0]  sh_reg;
    logic [XW+2:0]    rem_reg;
    logic [XW-1:0]    q_reg;

    logic [HW-1:0]    a_half;
    logic [HW-1:0]    b_half;
    logic [XW-1:0]    pp_c;
    logic [2*XW-1:0]  pp_sh;
    logic [XW+2:0]    minu;
    logic [XW+2:0]    subt;
    logic [XW+3:0]    diff;
    logic             ge;
    logic             div_ovf;

    // partial product k: a half k[1], b half k[0]
    assign a_half = cnt_reg[1] ? a_reg[XW-1:HW] : a_reg[HW-1:0];
    assign b_half = cnt_reg[0] ? b_reg[XW-1:HW] : b_reg[HW-1:0];
    assign pp_c   = a_half * b_half;

    // quotient would not fit: clamp at once
    assign div_ovf = (XW'(opa[XW-1:HW]) >= opb);

    always_comb begin
        case (kp_reg)
            2'd0:    pp_sh = {{XW{1'b0}}, pp_reg};
            2'd3:    pp_sh = {pp_reg, {XW{1'b0}}};
            default: pp_sh = {{HW{1'b0}}, pp_reg, {HW{1'b0}}};
        endcase
    end

    // shared subtractor: divide brings in one bit, root brings in two
    always_comb begin
        if (op_reg == OP_SQRT) begin
            minu = {rem_reg[XW:0], sh_reg[2*XW-1 -: 2]};
            subt = {1'b0, q_reg, 2'b01};
        end else begin
            minu = {rem_reg[XW+1:0], sh_reg[2*XW-1]};
            subt = {3'b000, b_reg};
        end
        diff = {1'b0, minu} - {1'b0, subt};
        ge   = !diff[XW+3];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            dsat_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end else begin
            if (cmd.start) begin
                op_reg   <= cmd.op;
                a_reg    <= opa;
                b_reg    <= opb;
                cnt_reg  <= '0;
                acc_reg  <= '0;
                case (cmd.op)
                    OP_DIV: begin
                        rem_reg  <= (XW+3)'(opa[XW-1:HW]);
                        sh_reg   <= {opa[HW-1:0], (XW+HW)'(0)};
                        q_reg    <= div_ovf ? '1 : '0;
                        dsat_reg <= div_ovf;
                        busy_reg <= !div_ovf;
                        done_reg <= div_ovf;
                    end
                    OP_SQRT: begin
                        rem_reg  <= '0;
                        sh_reg   <= {opa, XW'(0)} >> FRAC_BITS;
                        q_reg    <= '0;
                        dsat_reg <= 1'b0;
                        busy_reg <= 1'b1;
                        done_reg <= 1'b0;
                    end
                    default: begin
                        rem_reg  <= '0;
                        sh_reg   <= '0;
                        q_reg    <= '0;
                        dsat_reg <= 1'b0;
                        busy_reg <= 1'b1;
                        done_reg <= 1'b0;
                    end
                endcase
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                case (op_reg)
                    OP_MUL: begin
                        if (cnt_reg < MUL_LAST) begin
                            pp_reg <= pp_c;
                            kp_reg <= cnt_reg[1:0];
                        end
                        if (cnt_reg != '0) begin
                            acc_reg <= acc_reg + pp_sh;
                        end
                        busy_reg <= (cnt_reg != MUL_LAST);
                        done_reg <= (cnt_reg == MUL_LAST);
                    end
                    OP_DIV, OP_SQRT: begin
                        rem_reg  <= ge ? diff[XW+2:0] : minu;
                        q_reg    <= {q_reg[XW-2:0], ge};
                        sh_reg   <= (op_reg == OP_SQRT) ? (sh_reg << 2) : (sh_reg << 1);
                        busy_reg <= (cnt_reg != ITER_LAST);
                        done_reg <= (cnt_reg == ITER_LAST);
                    end
                    default: begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                endcase
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign stat.done    = done_reg;
    assign stat.div_sat = dsat_reg;
    assign prod         = acc_reg;
    assign quo          = q_reg;

endmodule

`default_nettype wire

@@ sv/adam_parameter_update.sv @@
// ----------------------------------------------------------------------------
// Adam parameter update
// Parameter table with per-entry Adam moments, updated in signed Q8.24.
// ----------------------------------------------------------------------------
// Input words arrive on the s_ stream: tuser carries the request kind (load,
// gradient, advance, ignore), tdata the entry index and the value. Every
// input word gives exactly one result word on the m_ stream: index, new
// parameter and a saturation flag. The learning rate, both betas and epsilon
// are set through the cfg_ write port; the user must do so only while the
// block is idle, as the block itself does not enforce it.
// One word is in flight at a time; s_tready is high only between items.
// Each item first reduces its index modulo the table depth by a reciprocal
// multiply and a multiply back. A load then writes the table, an advance
// takes two multiplies, a gradient eight multiplies and two divides, one root
// and a final divide, all on the one shared arithmetic unit.
// The result sits in an output register; if the receiver stalls, the next
// item is still accepted and its result waits until the register is free.
// Reset (aresetn, synchronous) restores the register defaults and sets both
// beta powers to one; table contents stay undefined until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "adam_parameter_update_defines.svh"

module adam_parameter_update
    import apu_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int DW = ((IDX_W + VALUE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [DW-1:0]        s_tdata,    // entry_index, data_value
    input  wire logic [TYPE_W-1:0]    s_tuser,    // req_type
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [DW-1:0]             m_tdata,    // result_index, param_value
    output logic [0:0]                m_tuser,    // saturated
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    localparam int VW = VALUE_WIDTH;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [XW-1:0] VMASK = (XW'(1) << VW) - XW'(1);
    localparam logic signed [XW+1:0] SMAX_X = signed'({2'b00, VMASK >> 1});
    localparam logic signed [XW+1:0] SMIN_X = ~SMAX_X;
    // reciprocal of the depth, exact for every 10-bit index
    localparam int RCP_SH = IDX_W + 17;
    localparam logic [RCP_SH-1:0] RCP_C =
        RCP_SH'((2**RCP_SH + TABLE_DEPTH - 1) / TABLE_DEPTH);
    localparam logic [IDX_W-1:0] DEPTH_LO = IDX_W'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_MOD, S_RD, S_CAP, S_ISSUE, S_WAIT, S_WRITE, S_FINISH
    } state_t;

    typedef enum logic [3:0] {
        ST_T1, ST_T2, ST_G2, ST_U1, ST_U2, ST_D1, ST_D2,
        ST_MH, ST_VH, ST_RT, ST_ADJ, ST_STEP, ST_ADV1, ST_ADV2
    } step_t;

    state_t                  state_reg;
    step_t                   step_reg;
    req_t                    type_reg;
    logic [IDX_W-1:0]        idx_sh_reg;
    logic [IDX_W-1:0]        quot_reg;
    logic [IDX_W-1:0]        rem_reg;
    logic [3:0]              cnt_reg;
    logic signed [VW-1:0]    data_reg;

    logic [CFG_W-1:0]        lr_reg, b1_reg, b2_reg, eps_reg;
    logic [32:0]             bfp_reg, bsp_reg;

    logic signed [XW-1:0]    m_old_reg, p_old_reg, mn_reg, p_reg;
    logic [XW-1:0]           v_old_reg, t1_reg, g2_reg, u1_reg, vn_reg;
    logic [XW-1:0]           d1_reg, d2_reg, mh_reg, vh_reg, den_reg, adj_reg;
    logic                    sat_reg;

    logic                    m_valid_reg;
    logic [IDX_W-1:0]        out_idx_reg;
    logic [VW-1:0]           out_val_reg;
    logic                    out_sat_reg;

    // arithmetic unit
    arith_cmd_t              cmd;
    arith_stat_t             stat;
    logic [XW-1:0]           opa, opb;
    logic [2*XW-1:0]         prod;
    logic [XW-1:0]           quo;

    // memory
    logic                    ram_we;
    logic [AW-1:0]           addr;
    logic [3*VW-1:0]         ram_wdata, ram_rdata;

    // misc datapath
    logic [IDX_W+RCP_SH-1:0] mod_prod;
    logic [IDX_W-1:0]        mod_back;
    logic signed [XW-1:0]    g_x, m1;
    logic [XW-1:0]           g_mag, m_mag, mn_mag;
    logic [XW-1:0]           b1_x, b2_x;
    logic                    mr32_sat, mr24_sat;
    logic [XW-1:0]           mr32, mr24;
    logic [XW:0]             vsum;
    logic [XW-1:0]           den_c;
    logic [XW:0]             mn_clamp, p_clamp;

    function automatic logic [XW-1:0] mag_of(input logic signed [XW-1:0] x);
        logic [XW-1:0] ux;
        begin
            ux = x;
            mag_of = ux[XW-1] ? (~ux + XW'(1)) : ux;
        end
    endfunction

    // p + mag or p - mag, clamped to the signed value range; top bit is the flag
    function automatic logic [XW:0] clamp_add(input logic signed [XW-1:0] p,
                                              input logic sub,
                                              input logic [XW-1:0] mag);
        logic signed [XW+1:0] ps, ms, s;
        begin
            ps = (XW+2)'(p);
            ms = signed'({2'b00, mag});
            s  = sub ? (ps - ms) : (ps + ms);
            if (s > SMAX_X) begin
                clamp_add = {1'b1, SMAX_X[XW-1:0]};
            end else if (s < SMIN_X) begin
                clamp_add = {1'b1, SMIN_X[XW-1:0]};
            end else begin
                clamp_add = {1'b0, s[XW-1:0]};
            end
        end
    endfunction

    // index modulo depth: quotient first, then the remainder
    assign mod_prod = (IDX_W+RCP_SH)'(idx_sh_reg) * (IDX_W+RCP_SH)'(RCP_C);
    assign mod_back = quot_reg * DEPTH_LO;
    assign addr     = AW'(rem_reg);

    assign g_x    = XW'(data_reg);
    assign g_mag  = mag_of(g_x);
    assign m_mag  = mag_of(m_old_reg);
    assign mn_mag = mag_of(mn_reg);
    assign b1_x   = XW'(b1_reg);
    assign b2_x   = XW'(b2_reg);

    // product taken down by 32 or by 24 bits, clamped to 64 bits
    assign mr32_sat = |prod[2*XW-1:XW+32];
    assign mr32     = mr32_sat ? '1 : prod[XW+31:32];
    assign mr24_sat = |prod[2*XW-1:XW+FRAC_BITS];
    assign mr24     = mr24_sat ? '1 : prod[XW+FRAC_BITS-1:FRAC_BITS];

    assign m1       = m_old_reg[XW-1] ? -signed'(t1_reg) : signed'(t1_reg);
    assign mn_clamp = clamp_add(m1, g_x[XW-1], mr32);
    assign p_clamp  = clamp_add(p_old_reg, !mn_reg[XW-1], mr32);
    assign vsum     = {1'b0, u1_reg} + {1'b0, mr32};
    assign den_c    = quo + XW'(eps_reg);

    always_comb begin
        cmd.start = (state_reg == S_ISSUE);
        cmd.op    = OP_MUL;
        opa       = '0;
        opb       = '0;
        case (step_reg)
            ST_T1:   begin opa = m_mag;             opb = b1_x;           end
            ST_T2:   begin opa = g_mag;             opb = ONE_Q32 - b1_x; end
            ST_G2:   begin opa = g_mag;             opb = g_mag;          end
            ST_U1:   begin opa = v_old_reg;         opb = b2_x;           end
            ST_U2:   begin opa = g2_reg;            opb = ONE_Q32 - b2_x; end
            ST_D1, ST_ADV1: begin opa = XW'(bfp_reg); opb = b1_x;         end
            ST_D2, ST_ADV2: begin opa = XW'(bsp_reg); opb = b2_x;         end
            ST_MH:   begin cmd.op = OP_DIV;  opa = mn_mag; opb = d1_reg;  end
            ST_VH:   begin cmd.op = OP_DIV;  opa = vn_reg; opb = d2_reg;  end
            ST_RT:   begin cmd.op = OP_SQRT; opa = vh_reg;                end
            ST_ADJ:  begin cmd.op = OP_DIV;  opa = mh_reg; opb = den_reg; end
            ST_STEP: begin opa = adj_reg;           opb = XW'(lr_reg);    end
            default: begin opa = '0;                opb = '0;             end
        endcase
    end

    apu_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .opa     (opa),
        .opb     (opb),
        .stat    (stat),
        .prod    (prod),
        .quo     (quo)
    );

    // entry word: {second moment, first moment, parameter}
    assign ram_we = (state_reg == S_WRITE);
    assign ram_wdata = (type_reg == REQ_LOAD)
                     ? {VW'(0), VW'(0), data_reg}
                     : {vn_reg[VW-1:0], mn_reg[VW-1:0], p_reg[VW-1:0]};

    apu_ram #(
        .WIDTH (3 * VW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (addr),
        .wdata (ram_wdata),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            step_reg    <= ST_T1;
            type_reg    <= REQ_IGNORE;
            m_valid_reg <= 1'b0;
            sat_reg     <= 1'b0;
            lr_reg      <= LR_RST;
            b1_reg      <= B1_RST;
            b2_reg      <= B2_RST;
            eps_reg     <= EPS_RST;
            bfp_reg     <= ONE_Q32[32:0];
            bsp_reg     <= ONE_Q32[32:0];
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_LR:    lr_reg  <= cfg_wdata;
                    CFG_BETA1: b1_reg  <= cfg_wdata;
                    CFG_BETA2: b2_reg  <= cfg_wdata;
                    CFG_EPS:   eps_reg <= cfg_wdata;
                    default:   ;
                endcase
            end

            // S_FINISH handles the output register itself
            if (m_valid_reg && m_tready && (state_reg != S_FINISH)) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        type_reg   <= req_t'(s_tuser);
                        idx_sh_reg <= s_tdata[IDX_W-1:0];
                        data_reg   <= s_tdata[IDX_W +: VW];
                        cnt_reg    <= '0;
                        sat_reg    <= 1'b0;
                        state_reg  <= S_MOD;
                    end
                end
                S_MOD: begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd0) begin
                        quot_reg <= mod_prod[IDX_W+RCP_SH-1:RCP_SH];
                    end else begin
                        rem_reg <= idx_sh_reg - mod_back;
                        case (type_reg)
                            REQ_LOAD: state_reg <= S_WRITE;
                            REQ_GRAD: state_reg <= S_RD;
                            REQ_ADV: begin
                                step_reg  <= ST_ADV1;
                                state_reg <= S_ISSUE;
                            end
                            default:  state_reg <= S_FINISH;
                        endcase
                    end
                end
                S_RD: begin
                    state_reg <= S_CAP;
                end
                S_CAP: begin
                    p_old_reg <= XW'(signed'(ram_rdata[VW-1:0]));
                    m_old_reg <= XW'(signed'(ram_rdata[VW +: VW]));
                    v_old_reg <= XW'(ram_rdata[2*VW +: VW]);
                    step_reg  <= ST_T1;
                    state_reg <= S_ISSUE;
                end
                S_ISSUE: begin
                    state_reg <= S_WAIT;
                end
                S_WAIT: begin
                    if (stat.done) begin
                        case (step_reg)
                            ST_T1: begin
                                t1_reg    <= mr32;
                                sat_reg   <= sat_reg | mr32_sat;
                                step_reg  <= ST_T2;
                                state_reg <= S_ISSUE;
                            end
                            ST_T2: begin
                                mn_reg    <= mn_clamp[XW-1:0];
                                sat_reg   <= sat_reg | mr32_sat | mn_clamp[XW];
                                step_reg  <= ST_G2;
                                state_reg <= S_ISSUE;
                            end
                            ST_G2: begin
                                g2_reg    <= mr24;
                                sat_reg   <= sat_reg | mr24_sat;
                                step_reg  <= ST_U1;
                                state_reg <= S_ISSUE;
                            end
                            ST_U1: begin
                                u1_reg    <= mr32;
                                sat_reg   <= sat_reg | mr32_sat;
                                step_reg  <= ST_U2;
                                state_reg <= S_ISSUE;
                            end
                            ST_U2: begin
                                if (vsum[XW] || (vsum[XW-1:0] > VMASK)) begin
                                    vn_reg  <= VMASK;
                                    sat_reg <= 1'b1;
                                end else begin
                                    vn_reg  <= vsum[XW-1:0];
                                    sat_reg <= sat_reg | mr32_sat;
                                end
                                step_reg  <= ST_D1;
                                state_reg <= S_ISSUE;
                            end
                            ST_D1: begin
                                d1_reg    <= ONE_Q32 - mr32;
                                sat_reg   <= sat_reg | mr32_sat;
                                step_reg  <= ST_D2;
                                state_reg <= S_ISSUE;
                            end
                            ST_D2: begin
                                d2_reg    <= ONE_Q32 - mr32;
                                sat_reg   <= sat_reg | mr32_sat;
                                step_reg  <= ST_MH;
                                state_reg <= S_ISSUE;
                            end
                            ST_MH: begin
                                mh_reg    <= quo;
                                sat_reg   <= sat_reg | stat.div_sat;
                                step_reg  <= ST_VH;
                                state_reg <= S_ISSUE;
                            end
                            ST_VH: begin
                                vh_reg    <= quo;
                                sat_reg   <= sat_reg | stat.div_sat;
                                step_reg  <= ST_RT;
                                state_reg <= S_ISSUE;
                            end
                            ST_RT: begin
                                den_reg   <= den_c;
                                state_reg <= S_ISSUE;
                                if (den_c == '0) begin
                                    // zero denominator: skip the divide
                                    adj_reg  <= (mh_reg != '0) ? '1 : '0;
                                    sat_reg  <= sat_reg | (mh_reg != '0);
                                    step_reg <= ST_STEP;
                                end else begin
                                    step_reg <= ST_ADJ;
                                end
                            end
                            ST_ADJ: begin
                                adj_reg   <= quo;
                                sat_reg   <= sat_reg | stat.div_sat;
                                step_reg  <= ST_STEP;
                                state_reg <= S_ISSUE;
                            end
                            ST_STEP: begin
                                p_reg     <= p_clamp[XW-1:0];
                                sat_reg   <= sat_reg | mr32_sat | p_clamp[XW];
                                state_reg <= S_WRITE;
                            end
                            ST_ADV1: begin
                                bfp_reg   <= mr32[32:0];
                                step_reg  <= ST_ADV2;
                                state_reg <= S_ISSUE;
                            end
                            ST_ADV2: begin
                                bsp_reg   <= mr32[32:0];
                                state_reg <= S_FINISH;
                            end
                            default: state_reg <= S_FINISH;
                        endcase
                    end
                end
                S_WRITE: begin
                    state_reg <= S_FINISH;
                end
                S_FINISH: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                        case (type_reg)
                            REQ_LOAD: begin
                                out_idx_reg <= rem_reg;
                                out_val_reg <= data_reg;
                                out_sat_reg <= 1'b0;
                            end
                            REQ_GRAD: begin
                                out_idx_reg <= rem_reg;
                                out_val_reg <= p_reg[VW-1:0];
                                out_sat_reg <= sat_reg;
                            end
                            default: begin
                                out_idx_reg <= '0;
                                out_val_reg <= '0;
                                out_sat_reg <= 1'b0;
                            end
                        endcase
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready   = (state_reg == S_IDLE);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = DW'({out_val_reg, out_idx_reg});
    assign m_tuser[0] = out_sat_reg;

    `APU_ASSERT_NXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready,
                    "new word taken while an item is in flight")
    `APU_ASSERT_IMP(a_write_busy, aclk, aresetn, ram_we, !s_tready,
                    "table written while idle")
    `APU_ASSERT_IMP(a_done_waited, aclk, aresetn, stat.done, state_reg == S_WAIT,
                    "arithmetic result with no step waiting")

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// Adam parameter update - testbench
// Drives load, gradient, advance and unused request words on the input stream
// under random source and sink stalls. A built-in Adam update predictor works
// out each result word, and every result word on the output stream is checked
// against it field by field. Covers reset defaults and extreme register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;
    import apu_pkg::*;

    localparam int  DW        = 48;
    localparam int  NDEPTH    = 1024;
    localparam int  CYC_LIMIT = 2000000;
    localparam logic signed [67:0] VMAX = 68'sd2147483647;
    localparam logic signed [67:0] VMIN = -68'sd2147483648;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [31:0]      value;
        logic             sat;
    } upd_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [DW-1:0]        s_tdata = '0;       // entry_index, data_value
    logic [TYPE_W-1:0]    s_tuser = '0;       // req_type
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [DW-1:0]        m_tdata;            // result_index, param_value
    logic [0:0]           m_tuser;            // saturated
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // predictor state
    logic [31:0] lr_q, b1_q, b2_q, eps_q;
    logic [31:0] par_tab [NDEPTH];
    logic [31:0] mom1_tab [NDEPTH];
    logic [31:0] mom2_tab [NDEPTH];
    logic [32:0] pow1, pow2;
    int          loaded_pool [$];
    upd_result_t pending_results [$];

    int  fails = 0;
    int  cycles = 0;
    bit  no_idle = 1'b0;

    adam_parameter_update u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 38);
    end

    // ---- arithmetic of the update ----
    function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int s,
                                            inout bit sat);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        if ((p >> (64 + s)) != 0) begin
            sat = 1'b1;
            return '1;
        end
        return 64'(p >> s);
    endfunction

    function automatic logic [63:0] div_sat(logic [127:0] num, logic [63:0] d, inout bit sat);
        if (num[127:64] >= d) begin
            sat = 1'b1;
            return '1;
        end
        return 64'(num / {64'b0, d});
    endfunction

    function automatic logic [63:0] root128(logic [127:0] x);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] sq;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            sq = {64'b0, c} * {64'b0, c};
            if (sq <= x) r = c;
        end
        return r;
    endfunction

    function automatic logic [31:0] clamp_sum(longint p, bit sub, logic [63:0] mag,
                                              inout bit sat);
        logic signed [67:0] ps, ms, r;
        ps = p;
        ms = $signed({4'b0, mag});
        r = sub ? ps - ms : ps + ms;
        if (r > VMAX) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (r < VMIN) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return r[31:0];
    endfunction

    function automatic upd_result_t predict_update(req_t kind, logic [IDX_W-1:0] idx,
                                                   logic [31:0] data);
        upd_result_t res;
        bit          sat;
        longint      g, m, m1, p;
        logic [63:0] gmag, t1, t2, v, g2, u1, u2, d1, d2, mmag, mh, vh, rt, den, adj, stp;
        logic [64:0] vsum;
        logic [31:0] mn;
        res = '0;
        sat = 1'b0;
        case (kind)
            REQ_LOAD: begin
                par_tab[idx]  = data;
                mom1_tab[idx] = '0;
                mom2_tab[idx] = '0;
                res.idx   = idx;
                res.value = data;
            end
            REQ_GRAD: begin
                g    = longint'($signed(data));
                gmag = (g < 0) ? 64'(-g) : 64'(g);
                m    = longint'($signed(mom1_tab[idx]));
                t1   = mul_shr((m < 0) ? 64'(-m) : 64'(m), {32'b0, b1_q}, 32, sat);
                t2   = mul_shr(gmag, ONE_Q32 - {32'b0, b1_q}, 32, sat);
                m1   = (m < 0) ? -longint'(t1) : longint'(t1);
                mn   = clamp_sum(m1, g < 0, t2, sat);
                v    = {32'b0, mom2_tab[idx]};
                g2   = mul_shr(gmag, gmag, FRAC_BITS, sat);
                u1   = mul_shr(v, {32'b0, b2_q}, 32, sat);
                u2   = mul_shr(g2, ONE_Q32 - {32'b0, b2_q}, 32, sat);
                vsum = {1'b0, u1} + {1'b0, u2};
                if (vsum > 65'h0_FFFF_FFFF) begin
                    vsum = 65'h0_FFFF_FFFF;
                    sat = 1'b1;
                end
                mom1_tab[idx] = mn;
                mom2_tab[idx] = vsum[31:0];
                d1   = ONE_Q32 - mul_shr({31'b0, pow1}, {32'b0, b1_q}, 32, sat);
                d2   = ONE_Q32 - mul_shr({31'b0, pow2}, {32'b0, b2_q}, 32, sat);
                mmag = $signed(mn) < 0 ? 64'(-longint'($signed(mn))) : {32'b0, mn};
                mh   = div_sat({32'b0, mmag, 32'b0}, d1, sat);
                vh   = div_sat({32'b0, 32'b0, vsum[31:0], 32'b0}, d2, sat);
                rt   = root128({24'b0, vh, 40'b0});
                den  = rt + {32'b0, eps_q};
                if (den == 0) begin
                    // root plus guard is zero: only a non-zero mhat clamps
                    if (mh != 0) begin
                        adj = '1;
                        sat = 1'b1;
                    end else begin
                        adj = '0;
                    end
                end else begin
                    adj = div_sat({32'b0, mh, 32'b0}, den, sat);
                end
                stp  = mul_shr(adj, {32'b0, lr_q}, 32, sat);
                p    = longint'($signed(par_tab[idx]));
                par_tab[idx] = clamp_sum(p, $signed(mn) >= 0, stp, sat);
                res.idx   = idx;
                res.value = par_tab[idx];
                res.sat   = sat;
            end
            REQ_ADV: begin
                pow1 = 33'(mul_shr({31'b0, pow1}, {32'b0, b1_q}, 32, sat));
                pow2 = 33'(mul_shr({31'b0, pow2}, {32'b0, b2_q}, 32, sat));
            end
            default: ;
        endcase
        return res;
    endfunction

    // ---- result checker ----
    always @(posedge aclk) begin
        upd_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word idx=%0d value=%h sat=%b", $time,
                         m_tdata[9:0], m_tdata[41:10], m_tuser[0]);
                fails = fails + 1;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[9:0] !== want.idx) begin
                    $display("%0t: result_index expected %0d got %0d", $time, want.idx,
                             m_tdata[9:0]);
                    fails = fails + 1;
                end
                if (m_tdata[41:10] !== want.value) begin
                    $display("%0t: param_value expected %h got %h", $time, want.value,
                             m_tdata[41:10]);
                    fails = fails + 1;
                end
                if (m_tdata[DW-1:42] !== '0) begin
                    $display("%0t: tdata padding expected 0 got %h", $time, m_tdata[DW-1:42]);
                    fails = fails + 1;
                end
                if (m_tuser[0] !== want.sat) begin
                    $display("%0t: saturated expected %b got %b", $time, want.sat, m_tuser[0]);
                    fails = fails + 1;
                end
            end
        end
    end

    // ---- drivers ----
    task automatic send_word(req_t kind, logic [IDX_W-1:0] idx, logic [31:0] data);
        int gap;
        gap = (!no_idle && $urandom_range(99) < 38) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'b0, data, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_update(kind, idx, data));
        if (kind == REQ_LOAD) loaded_pool.push_back(idx);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] ri, logic [31:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= ri;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (ri)
            CFG_LR:    lr_q  = val;
            CFG_BETA1: b1_q  = val;
            CFG_BETA2: b2_q  = val;
            default:   eps_q = val;
        endcase
    endtask

    task automatic set_all(logic [31:0] lr, logic [31:0] b1, logic [31:0] b2,
                           logic [31:0] eps);
        write_reg(CFG_LR, lr);
        write_reg(CFG_BETA1, b1);
        write_reg(CFG_BETA2, b2);
        write_reg(CFG_EPS, eps);
    endtask

    // lets every pending word come back, then a margin for the output register
    task automatic drain();
        @(posedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic logic [IDX_W-1:0] pick_loaded();
        return IDX_W'(loaded_pool[$urandom_range(loaded_pool.size() - 1)]);
    endfunction

    function automatic logic [31:0] rand_grad();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return 32'($signed($urandom) >>> 8);
            default: return 32'($signed($urandom) >>> $urandom_range(9, 24));
        endcase
    endfunction

    // ---- tests ----
    task automatic test_defaults();
        send_word(REQ_LOAD, 10'd0, 32'h0100_0000);
        send_word(REQ_LOAD, 10'd1023, 32'h7FFF_FFFF);
        send_word(REQ_LOAD, 10'd512, 32'h8000_0000);
        send_word(REQ_GRAD, 10'd0, 32'h0000_0000);
        send_word(REQ_GRAD, 10'd0, 32'h0100_0000);
        send_word(REQ_GRAD, 10'd1023, 32'h8000_0000);
        send_word(REQ_GRAD, 10'd512, 32'h7FFF_FFFF);
        send_word(REQ_ADV, 10'h3FF, 32'hFFFF_FFFF);
        send_word(REQ_GRAD, 10'd0, 32'hFF00_0000);
        send_word(REQ_IGNORE, 10'h2AA, 32'h5555_5555);
        send_word(REQ_GRAD, 10'd512, 32'h0000_0001);
        drain();
    endtask

    task automatic test_zero_denominator();
        // beta1 zero with tiny gradient gives non-zero mhat over a zero root
        set_all(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
        send_word(REQ_LOAD, 10'd7, 32'h0000_1000);
        send_word(REQ_GRAD, 10'd7, 32'h0000_0001);
        send_word(REQ_LOAD, 10'd8, 32'hFFFF_0000);
        send_word(REQ_GRAD, 10'd8, 32'h0000_0000);
        send_word(REQ_ADV, 10'd0, 32'd0);
        send_word(REQ_GRAD, 10'd8, 32'hFFFF_FFFF);
        drain();
    endtask

    task automatic test_extreme_config();
        set_all(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(REQ_GRAD, 10'd1023, 32'h7FFF_FFFF);
        send_word(REQ_ADV, 10'd3, 32'd0);
        send_word(REQ_GRAD, 10'd0, 32'h8000_0000);
        send_word(REQ_GRAD, 10'd512, 32'h0123_4567);
        drain();
    endtask

    task automatic test_random_mix(int n_words);
        int sel;
        for (int i = 0; i < n_words; i++) begin
            if (i == n_words / 3) no_idle = 1'b1;
            if (i == n_words / 2) begin
                no_idle = 1'b0;
                drain();
                set_all($urandom, $urandom, $urandom, $urandom_range(0, 4095));
            end
            if (i == (2 * n_words) / 3) begin
                drain();
                set_all($urandom_range(1, 50000000), 32'hE666_6666 + $urandom_range(0, 1 << 24),
                        32'hFFBE_0000 + $urandom_range(0, 1 << 20), $urandom_range(0, 100));
            end
            sel = $urandom_range(99);
            if (sel < 10 || loaded_pool.size() < 4) begin
                send_word(REQ_LOAD, 10'($urandom), 32'($signed($urandom) >>> $urandom_range(0, 7)));
            end else if (sel < 78) begin
                send_word(REQ_GRAD, pick_loaded(), rand_grad());
            end else if (sel < 88) begin
                send_word(REQ_ADV, 10'($urandom), $urandom);
            end else if (sel < 93) begin
                send_word(REQ_IGNORE, 10'($urandom), $urandom);
            end else begin
                send_word(REQ_LOAD, pick_loaded(), $urandom);
            end
        end
        drain();
    endtask

    initial begin
        lr_q  = LR_RST;
        b1_q  = B1_RST;
        b2_q  = B2_RST;
        eps_q = EPS_RST;
        pow1  = 33'h1_0000_0000;
        pow2  = 33'h1_0000_0000;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_defaults();
        test_zero_denominator();
        test_extreme_config();
        set_all(LR_RST, B1_RST, B2_RST, EPS_RST);
        test_random_mix(500);
        if (fails == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
